>>> hw/rtl/qadr_pkg.sv
// Package for the four-channel downmix router: widths, register indexes,
// layout and host codes, reset values and the types shared by its modules.
// Depends on nothing; every other file of the block imports it.
package qadr_pkg;

    localparam int GAIN_W            = 16;
    localparam int OUT_W             = 16;
    localparam int SLOTS             = 4;
    localparam int CFG_IDX_W         = 3;
    localparam int CFG_DATA_W        = 16;
    localparam int COUNT_W           = 3;
    localparam int SAMPLE_BITS_DEF   = 18;
    localparam int GAIN_FRAC_DEF     = 15;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAIN_FL    = 3'd0,
        CFG_GAIN_FR    = 3'd1,
        CFG_GAIN_RL    = 3'd2,
        CFG_GAIN_RR    = 3'd3,
        CFG_HOST       = 3'd4,
        CFG_LAYOUT     = 3'd5,
        CFG_SWAP       = 3'd6,
        CFG_RESERVED   = 3'd7
    } cfg_index_t;

    typedef enum logic [1:0] {
        HOST_ONE    = 2'd0,
        HOST_TWO    = 2'd1,
        HOST_FOUR   = 2'd2,
        HOST_UNUSED = 2'd3
    } host_t;

    typedef enum logic [2:0] {
        LAYOUT_MONO      = 3'd0,
        LAYOUT_STEREO_LR = 3'd1,
        LAYOUT_STEREO_RL = 3'd2,
        LAYOUT_QUAD_FLR  = 3'd3,
        LAYOUT_QUAD_FRL  = 3'd4,
        LAYOUT_QUAD_RLR  = 3'd5,
        LAYOUT_QUAD_RRL  = 3'd6,
        LAYOUT_SPLIT     = 3'd7
    } layout_t;

    localparam logic [GAIN_W-1:0]  GAIN_RESET = 16'd32768;

    localparam logic [COUNT_W-1:0] COUNT_ONE  = 3'd1;
    localparam logic [COUNT_W-1:0] COUNT_TWO  = 3'd2;
    localparam logic [COUNT_W-1:0] COUNT_FOUR = 3'd4;

    // Routing controls handed from the register bank to the router.
    typedef struct packed {
        host_t   host;
        layout_t layout;
        logic    swap;
    } route_cfg_t;

    typedef logic [SLOTS-1:0][OUT_W-1:0] slot_vec_t;

endpackage

>>> hw/rtl/qadr_gain_lane.sv
// One gain lane: multiplies a signed sample by an unsigned Q1.15 gain and
// registers the exact product. Depends on qadr_pkg for the gain width.
module qadr_gain_lane #(
    parameter int SAMPLE_BITS = qadr_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                          clk,
    input  logic                                          load,
    input  logic signed [SAMPLE_BITS-1:0]                 sample,
    input  logic        [qadr_pkg::GAIN_W-1:0]            gain,
    output logic signed [SAMPLE_BITS+qadr_pkg::GAIN_W:0]  product_reg
);
    import qadr_pkg::*;

    localparam int PROD_W = SAMPLE_BITS + GAIN_W + 1;

    logic signed [PROD_W-1:0] product_next;

    // The gain gets a zero sign bit so the product is signed by unsigned.
    assign product_next = PROD_W'(sample) * PROD_W'($signed({1'b0, gain}));

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            product_reg <= product_next;
        end
    end

endmodule

>>> hw/rtl/qadr_mix_router.sv
// Merging stage: forms pair and four-way mixes of the lane products, drops
// the fraction toward zero, saturates and routes to the slots. Uses qadr_pkg.
module qadr_mix_router #(
    parameter int SAMPLE_BITS    = qadr_pkg::SAMPLE_BITS_DEF,
    parameter int GAIN_FRAC_BITS = qadr_pkg::GAIN_FRAC_DEF
) (
    input  logic signed [SAMPLE_BITS+qadr_pkg::GAIN_W:0]  prod_fl,
    input  logic signed [SAMPLE_BITS+qadr_pkg::GAIN_W:0]  prod_fr,
    input  logic signed [SAMPLE_BITS+qadr_pkg::GAIN_W:0]  prod_rl,
    input  logic signed [SAMPLE_BITS+qadr_pkg::GAIN_W:0]  prod_rr,
    input  qadr_pkg::route_cfg_t                          route,
    output qadr_pkg::slot_vec_t                           slots,
    output logic [qadr_pkg::COUNT_W-1:0]                  count
);
    import qadr_pkg::*;

    localparam int PROD_W = SAMPLE_BITS + GAIN_W + 1;
    localparam int SUM_W  = PROD_W + 2;
    localparam logic signed [SUM_W-1:0] SAT_MAX = SUM_W'(32767);
    localparam logic signed [SUM_W-1:0] SAT_MIN = -SUM_W'(32768);

    // Divide by 2^(frac + extra) rounding toward zero, then clamp to 16 bits.
    function automatic logic [OUT_W-1:0] finish(input logic signed [SUM_W-1:0] v,
                                                input int extra);
        logic signed [SUM_W-1:0] bias;
        logic signed [SUM_W-1:0] q;
        bias = (SUM_W'(1) << (GAIN_FRAC_BITS + extra)) - SUM_W'(1);
        q = (v + (v[SUM_W-1] ? bias : SUM_W'(0))) >>> (GAIN_FRAC_BITS + extra);
        if (q > SAT_MAX)
        begin
            q = SAT_MAX;
        end
        else if (q < SAT_MIN)
        begin
            q = SAT_MIN;
        end
        return q[OUT_W-1:0];
    endfunction

    logic signed [SUM_W-1:0] fl, fr, rl, rr;
    logic [OUT_W-1:0] mono, mix_fl_rl, mix_fl_rr, mix_fr_rl, mix_fr_rr;
    logic [OUT_W-1:0] mix_front, mix_rear, one_fl, one_fr, one_rl, one_rr;
    logic             swap;

    assign fl = SUM_W'(prod_fl);
    assign fr = SUM_W'(prod_fr);
    assign rl = SUM_W'(prod_rl);
    assign rr = SUM_W'(prod_rr);

    assign mono      = finish(fl + fr + rl + rr, 2);
    assign mix_fl_rl = finish(fl + rl, 1);
    assign mix_fl_rr = finish(fl + rr, 1);
    assign mix_fr_rl = finish(fr + rl, 1);
    assign mix_fr_rr = finish(fr + rr, 1);
    assign mix_front = finish(fl + fr, 1);
    assign mix_rear  = finish(rl + rr, 1);
    assign one_fl    = finish(fl, 0);
    assign one_fr    = finish(fr, 0);
    assign one_rl    = finish(rl, 0);
    assign one_rr    = finish(rr, 0);

    // The reversed layouts flip the requested swap.
    assign swap = route.swap ^ ((route.layout == LAYOUT_STEREO_RL) ||
                                (route.layout == LAYOUT_QUAD_FRL) ||
                                (route.layout == LAYOUT_QUAD_RRL));

    always_comb
    begin
        slots = '0;
        count = COUNT_FOUR;
        unique case (route.host)
            HOST_ONE:
            begin
                slots[0] = mono;
                count    = COUNT_ONE;
            end
            HOST_TWO:
            begin
                slots[0] = swap ? mix_fr_rr : mix_fl_rl;
                slots[1] = swap ? mix_fl_rl : mix_fr_rr;
                count    = COUNT_TWO;
            end
            HOST_FOUR, HOST_UNUSED:
            begin
                unique case (route.layout)
                    LAYOUT_MONO:
                    begin
                        slots = {SLOTS{mono}};
                    end
                    LAYOUT_STEREO_LR, LAYOUT_STEREO_RL:
                    begin
                        slots[0] = swap ? mix_rear : mix_front;
                        slots[1] = swap ? mix_front : mix_rear;
                        slots[2] = swap ? mix_rear : mix_front;
                        slots[3] = swap ? mix_front : mix_rear;
                    end
                    LAYOUT_QUAD_FLR, LAYOUT_QUAD_FRL:
                    begin
                        slots[0] = swap ? one_fr : one_fl;
                        slots[1] = swap ? one_fl : one_fr;
                        slots[2] = swap ? one_rr : one_rl;
                        slots[3] = swap ? one_rl : one_rr;
                    end
                    LAYOUT_QUAD_RLR, LAYOUT_QUAD_RRL:
                    begin
                        slots[0] = swap ? one_rr : one_rl;
                        slots[1] = swap ? one_rl : one_rr;
                        slots[2] = swap ? one_fr : one_fl;
                        slots[3] = swap ? one_fl : one_fr;
                    end
                    LAYOUT_SPLIT:
                    begin
                        slots[0] = swap ? mix_fl_rr : mix_fl_rl;
                        slots[1] = swap ? mix_fl_rl : mix_fl_rr;
                        slots[2] = swap ? mix_fr_rr : mix_fr_rl;
                        slots[3] = swap ? mix_fr_rl : mix_fr_rr;
                    end
                    default:
                    begin
                        slots = '0;
                    end
                endcase
            end
            default:
            begin
                slots = '0;
            end
        endcase
    end

endmodule

>>> hw/rtl/quad_audio_downmix_router_unit.sv
// Top level of the four-channel balance and downmix router: register bank,
// four gain lanes, the mix router and the output register.
// Depends on qadr_pkg, qadr_gain_lane and qadr_mix_router.
//
// Channel   Handshake             Word contents
// -------   --------------------  --------------------------------------------
// config    cfg_valid/cfg_ready   cfg_index (register number), cfg_data
// input     in_valid/in_ready     front_left, front_right, rear_left,
//                                 rear_right, block_end
// output    out_valid/out_ready   slot_0..slot_3, slot_count, block_end_out
//
// An accepted word is registered in the lane multipliers and again after the
// mix router before it appears on the output.
// One word is accepted per clock as long as the output side keeps taking
// words; the input stalls only when both stage registers hold words and the
// output word is not taken.
// Reset returns all gains to unity, four host slots, quad layout and no swap.
// Configuration writes are always accepted.
module quad_audio_downmix_router_unit #(
    parameter int SAMPLE_BITS    = qadr_pkg::SAMPLE_BITS_DEF,
    parameter int GAIN_FRAC_BITS = qadr_pkg::GAIN_FRAC_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,

    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [qadr_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [qadr_pkg::CFG_DATA_W-1:0]       cfg_data,

    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic signed [SAMPLE_BITS-1:0]         front_left,
    input  logic signed [SAMPLE_BITS-1:0]         front_right,
    input  logic signed [SAMPLE_BITS-1:0]         rear_left,
    input  logic signed [SAMPLE_BITS-1:0]         rear_right,
    input  logic                                  block_end,

    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic signed [qadr_pkg::OUT_W-1:0]     slot_0,
    output logic signed [qadr_pkg::OUT_W-1:0]     slot_1,
    output logic signed [qadr_pkg::OUT_W-1:0]     slot_2,
    output logic signed [qadr_pkg::OUT_W-1:0]     slot_3,
    output logic [qadr_pkg::COUNT_W-1:0]          slot_count,
    output logic                                  block_end_out
);
    import qadr_pkg::*;

    localparam int PROD_W = SAMPLE_BITS + GAIN_W + 1;

    // Register bank. The user must keep the block idle whenever it is written;
    // the block does not enforce this. Lanes and router read the registers directly.
    logic [GAIN_W-1:0] gain_fl_reg, gain_fr_reg, gain_rl_reg, gain_rr_reg;
    route_cfg_t        route_reg;
    logic              cfg_write;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_fl_reg  <= GAIN_RESET;
            gain_fr_reg  <= GAIN_RESET;
            gain_rl_reg  <= GAIN_RESET;
            gain_rr_reg  <= GAIN_RESET;
            route_reg    <= '{host: HOST_FOUR, layout: LAYOUT_QUAD_FLR, swap: 1'b0};
        end
        else if (cfg_write)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_GAIN_FL:  gain_fl_reg <= cfg_data;
                CFG_GAIN_FR:  gain_fr_reg <= cfg_data;
                CFG_GAIN_RL:  gain_rl_reg <= cfg_data;
                CFG_GAIN_RR:  gain_rr_reg <= cfg_data;
                CFG_HOST:     route_reg.host   <= host_t'(cfg_data[1:0]);
                CFG_LAYOUT:   route_reg.layout <= layout_t'(cfg_data[2:0]);
                CFG_SWAP:     route_reg.swap   <= cfg_data[0];
                CFG_RESERVED: ;
                default:      ;
            endcase
        end
    end

    // Pipeline flow control. The output register takes a new word when it
    // is empty or its word leaves; the lane stage moves with it, or when it is empty.
    logic s1_valid_reg, s1_block_end_reg;
    logic out_valid_reg;
    logic out_move, s1_move, in_take;

    assign out_move = !out_valid_reg || out_ready;
    assign s1_move  = !s1_valid_reg || out_move;
    assign in_ready = s1_move;
    assign in_take  = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_move)
            begin
                s1_valid_reg <= in_valid;
            end
            if (out_move)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_block_end_reg <= block_end;
        end
    end

    // Four gain lanes, one per input channel.
    logic signed [PROD_W-1:0] prod_fl, prod_fr, prod_rl, prod_rr;

    qadr_gain_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_lane_fl (
        .clk(clk), .load(in_take), .sample(front_left),
        .gain(gain_fl_reg), .product_reg(prod_fl)
    );
    qadr_gain_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_lane_fr (
        .clk(clk), .load(in_take), .sample(front_right),
        .gain(gain_fr_reg), .product_reg(prod_fr)
    );
    qadr_gain_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_lane_rl (
        .clk(clk), .load(in_take), .sample(rear_left),
        .gain(gain_rl_reg), .product_reg(prod_rl)
    );
    qadr_gain_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_lane_rr (
        .clk(clk), .load(in_take), .sample(rear_right),
        .gain(gain_rr_reg), .product_reg(prod_rr)
    );

    // Merging stage: mixes, truncation, saturation and routing.
    slot_vec_t            slots_next;
    logic [COUNT_W-1:0]   count_next;

    qadr_mix_router #(
        .SAMPLE_BITS(SAMPLE_BITS),
        .GAIN_FRAC_BITS(GAIN_FRAC_BITS)
    ) u_router (
        .prod_fl(prod_fl), .prod_fr(prod_fr),
        .prod_rl(prod_rl), .prod_rr(prod_rr),
        .route(route_reg),
        .slots(slots_next),
        .count(count_next)
    );

    // Output register; it holds its word while the consumer stalls.
    slot_vec_t          slots_reg;
    logic [COUNT_W-1:0] slot_count_reg;
    logic               block_end_out_reg;

    always_ff @(posedge clk)
    begin
        if (out_move && s1_valid_reg)
        begin
            slots_reg         <= slots_next;
            slot_count_reg    <= count_next;
            block_end_out_reg <= s1_block_end_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign slot_0        = slots_reg[0];
    assign slot_1        = slots_reg[1];
    assign slot_2        = slots_reg[2];
    assign slot_3        = slots_reg[3];
    assign slot_count    = slot_count_reg;
    assign block_end_out = block_end_out_reg;

    // A word in the lane stage is never dropped while the output stalls.
    assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !out_move |=> s1_valid_reg)
        else $error("lane stage word lost during an output stall");

    // An accepted input word always reaches the lane stage.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_take |=> s1_valid_reg)
        else $error("accepted input word did not enter the lane stage");

    // The slot count is always one of the legal values.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (slot_count_reg == COUNT_ONE || slot_count_reg == COUNT_TWO ||
                           slot_count_reg == COUNT_FOUR))
        else $error("illegal slot count on a valid output word");

    // A one-slot word carries zeros in the unused slots.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && slot_count_reg == COUNT_ONE |->
            slots_reg[1] == '0 && slots_reg[2] == '0 && slots_reg[3] == '0)
        else $error("unused slots not zero on a one-slot word");

endmodule

>>> bench/tb_quad_audio_downmix_router_unit.sv
// Self-checking bench for the four-channel balance and downmix router.
// Drives frames and register writes into quad_audio_downmix_router_unit and checks every
// output word against a local bit-exact predictor. Depends on qadr_pkg and the RTL top.
module tb_quad_audio_downmix_router_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import qadr_pkg::*;

    localparam int SB        = SAMPLE_BITS_DEF;
    localparam int FRAC      = GAIN_FRAC_DEF;
    localparam int LONG_HOLD = 300;
    localparam int RAND_WORDS = 1350;

    localparam logic [SB-1:0] SAMPLE_MAX = {1'b0, {(SB-1){1'b1}}};
    localparam logic [SB-1:0] SAMPLE_MIN = {1'b1, {(SB-1){1'b0}}};
    localparam logic [SB-1:0] SAMPLE_NEG1 = {SB{1'b1}};

    // One input word: four channel samples and the block marker.
    typedef struct packed {
        logic signed [SB-1:0] fl;
        logic signed [SB-1:0] fr;
        logic signed [SB-1:0] rl;
        logic signed [SB-1:0] rr;
        logic                 block_end;
    } frame_t;

    // One output word as the block presents it; slots[0] is slot_0.
    typedef struct packed {
        slot_vec_t            slots;
        logic [COUNT_W-1:0]   count;
        logic                 block_end;
    } mix_result_t;

    logic clk;
    logic rst_n = 1'b0;

    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    logic                  in_valid    = 1'b0;
    logic                  in_ready;
    logic signed [SB-1:0]  front_left  = '0;
    logic signed [SB-1:0]  front_right = '0;
    logic signed [SB-1:0]  rear_left   = '0;
    logic signed [SB-1:0]  rear_right  = '0;
    logic                  block_end   = 1'b0;

    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic signed [OUT_W-1:0] slot_0, slot_1, slot_2, slot_3;
    logic [COUNT_W-1:0]    slot_count;
    logic                  block_end_out;

    quad_audio_downmix_router_unit u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .front_left    (front_left),
        .front_right   (front_right),
        .rear_left     (rear_left),
        .rear_right    (rear_right),
        .block_end     (block_end),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .slot_0        (slot_0),
        .slot_1        (slot_1),
        .slot_2        (slot_2),
        .slot_3        (slot_3),
        .slot_count    (slot_count),
        .block_end_out (block_end_out)
    );

    // Local copy of the register bank, updated as each write is accepted.
    logic [GAIN_W-1:0] gain_cfg [4] = '{GAIN_RESET, GAIN_RESET, GAIN_RESET, GAIN_RESET};
    host_t             host_cfg   = HOST_FOUR;
    layout_t           layout_cfg = LAYOUT_QUAD_FLR;
    logic              swap_cfg   = 1'b0;

    // Frames waiting to be driven, and output words still owed by the block.
    frame_t      pending_frames [$];
    mix_result_t owed_mixes     [$];
    frame_t      cur_frame;

    int queued_total  = 0;
    int checked_total = 0;
    int err_count     = 0;

    // Idling controls shared between the stimulus thread and the two handshake
    // processes. With idle_enabled low, neither side inserts random gaps.
    bit idle_enabled = 1'b1;
    bit hold_request = 1'b0;
    int send_gap     = 0;
    int hold_cnt     = 0;

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Mostly short gaps, a few long ones, and never an empty gap.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (r < 80)
            return $urandom_range(1, 3);
        else if (r < 95)
            return $urandom_range(4, 9);
        return $urandom_range(10, 40);
    endfunction

    // Truncate a fixed-point value with FRAC+extra fraction bits toward zero,
    // then clamp to the signed 16-bit output range. SystemVerilog signed
    // division already truncates toward zero, which is exactly what we need.
    function automatic logic [OUT_W-1:0] trunc_sat(longint v, int extra);
        longint q;
        q = v / (longint'(1) << (FRAC + extra));
        if (q > 32767)
            q = 32767;
        if (q < -32768)
            q = -32768;
        return q[OUT_W-1:0];
    endfunction

    // Predict the output word for one frame under the current register copy.
    function automatic mix_result_t mix_frame(frame_t f);
        longint      fl, fr, rl, rr;
        logic        swap;
        logic [OUT_W-1:0] lv, rv, mv, av, bv, cv, dv;
        mix_result_t r;
        fl = longint'($signed(f.fl)) * longint'(gain_cfg[0]);
        fr = longint'($signed(f.fr)) * longint'(gain_cfg[1]);
        rl = longint'($signed(f.rl)) * longint'(gain_cfg[2]);
        rr = longint'($signed(f.rr)) * longint'(gain_cfg[3]);
        r = '0;
        r.block_end = f.block_end;

        // The reversed layouts flip the requested swap; with one slot the
        // swap has no visible effect anyway.
        swap = swap_cfg;
        if (layout_cfg == LAYOUT_STEREO_RL || layout_cfg == LAYOUT_QUAD_FRL ||
            layout_cfg == LAYOUT_QUAD_RRL)
            swap = ~swap;

        mv = trunc_sat(fl + fr + rl + rr, 2);
        case (host_cfg)
            HOST_ONE: begin
                r.slots[0] = mv;
                r.count    = COUNT_ONE;
            end
            HOST_TWO: begin
                lv = trunc_sat(fl + rl, 1);
                rv = trunc_sat(fr + rr, 1);
                r.slots[0] = swap ? rv : lv;
                r.slots[1] = swap ? lv : rv;
                r.count    = COUNT_TWO;
            end
            default: begin
                // Four slots, and the unused host code behaves the same way.
                r.count = COUNT_FOUR;
                case (layout_cfg)
                    LAYOUT_MONO: begin
                        r.slots[0] = mv;
                        r.slots[1] = mv;
                        r.slots[2] = mv;
                        r.slots[3] = mv;
                    end
                    LAYOUT_STEREO_LR, LAYOUT_STEREO_RL: begin
                        lv = trunc_sat(fl + fr, 1);
                        rv = trunc_sat(rl + rr, 1);
                        r.slots[0] = swap ? rv : lv;
                        r.slots[1] = swap ? lv : rv;
                        r.slots[2] = r.slots[0];
                        r.slots[3] = r.slots[1];
                    end
                    LAYOUT_QUAD_FLR, LAYOUT_QUAD_FRL: begin
                        r.slots[0] = trunc_sat(swap ? fr : fl, 0);
                        r.slots[1] = trunc_sat(swap ? fl : fr, 0);
                        r.slots[2] = trunc_sat(swap ? rr : rl, 0);
                        r.slots[3] = trunc_sat(swap ? rl : rr, 0);
                    end
                    LAYOUT_QUAD_RLR, LAYOUT_QUAD_RRL: begin
                        r.slots[0] = trunc_sat(swap ? rr : rl, 0);
                        r.slots[1] = trunc_sat(swap ? rl : rr, 0);
                        r.slots[2] = trunc_sat(swap ? fr : fl, 0);
                        r.slots[3] = trunc_sat(swap ? fl : fr, 0);
                    end
                    default: begin
                        // Split remix: every front channel against every rear one.
                        av = trunc_sat(fl + rl, 1);
                        bv = trunc_sat(fl + rr, 1);
                        cv = trunc_sat(fr + rl, 1);
                        dv = trunc_sat(fr + rr, 1);
                        r.slots[0] = swap ? bv : av;
                        r.slots[1] = swap ? av : bv;
                        r.slots[2] = swap ? dv : cv;
                        r.slots[3] = swap ? cv : dv;
                    end
                endcase
            end
        endcase
        return r;
    endfunction

    // Sample mix: full-scale extremes, values near zero, values around the
    // 16-bit saturation edge, and plain random words over all 18 bits.
    function automatic logic [SB-1:0] rand_sample();
        int r;
        logic [SB-1:0] v;
        r = $urandom_range(99);
        if (r < 8)
            return SAMPLE_MAX;
        if (r < 16)
            return SAMPLE_MIN;
        if (r < 36) begin
            v = SB'($urandom_range(200));
            return SB'(v - SB'(100));
        end
        if (r < 56) begin
            v = SB'(32768 + $urandom_range(64) - 32);
            return $urandom_range(1) ? -v : v;
        end
        v = SB'($urandom());
        return v;
    endfunction

    function automatic logic [GAIN_W-1:0] rand_gain();
        int r;
        r = $urandom_range(99);
        if (r < 15)
            return '0;
        if (r < 40)
            return GAIN_RESET;
        if (r < 50)
            return '1;
        if (r < 85)
            return GAIN_W'($urandom_range(32768));
        return GAIN_W'($urandom());
    endfunction

    task automatic push_frame(logic [SB-1:0] a, logic [SB-1:0] b, logic [SB-1:0] c,
                              logic [SB-1:0] d, logic be);
        frame_t f;
        f.fl = a;
        f.fr = b;
        f.rl = c;
        f.rr = d;
        f.block_end = be;
        pending_frames.push_back(f);
        queued_total++;
    endtask

    // One register write over the config channel. The local copy follows the
    // same masking as the register bank: only the low bits of the narrow
    // fields matter, and the reserved index changes nothing.
    task automatic write_reg(cfg_index_t idx, logic [CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_GAIN_FL: gain_cfg[0] = data;
            CFG_GAIN_FR: gain_cfg[1] = data;
            CFG_GAIN_RL: gain_cfg[2] = data;
            CFG_GAIN_RR: gain_cfg[3] = data;
            CFG_HOST:    host_cfg    = host_t'(data[1:0]);
            CFG_LAYOUT:  layout_cfg  = layout_t'(data[2:0]);
            CFG_SWAP:    swap_cfg    = data[0];
            default: ;
        endcase
    endtask

    // Program the whole bank. The narrow registers sometimes carry junk in
    // their upper data bits, which the block must ignore.
    task automatic program_all(logic [GAIN_W-1:0] g0, logic [GAIN_W-1:0] g1,
                               logic [GAIN_W-1:0] g2, logic [GAIN_W-1:0] g3,
                               host_t h, layout_t l, logic s);
        logic [CFG_DATA_W-1:0] junk;
        write_reg(CFG_GAIN_FL, g0);
        write_reg(CFG_GAIN_FR, g1);
        write_reg(CFG_GAIN_RL, g2);
        write_reg(CFG_GAIN_RR, g3);
        junk = $urandom_range(1) ? CFG_DATA_W'($urandom()) : '0;
        write_reg(CFG_HOST, {junk[CFG_DATA_W-1:2], h});
        junk = $urandom_range(1) ? CFG_DATA_W'($urandom()) : '0;
        write_reg(CFG_LAYOUT, {junk[CFG_DATA_W-1:3], l});
        junk = $urandom_range(1) ? CFG_DATA_W'($urandom()) : '0;
        write_reg(CFG_SWAP, {junk[CFG_DATA_W-1:1], s});
    endtask

    // Hold off until every queued frame has come back as a checked word, then
    // let the two-stage pipeline settle before touching registers.
    task automatic wait_idle();
        while (checked_total != queued_total)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Input driver. A word is taken at an edge where valid and ready were both
    // high; the prediction is made right there, from the frame on the ports
    // and the register copy, which cannot change while words are in flight.
    // The next word goes out in the same edge so valid never drops between
    // back-to-back words.
    always @(posedge clk) begin
        if (rst_n) begin
            if (in_valid && in_ready)
                owed_mixes.push_back(mix_frame(cur_frame));
            if (!in_valid || in_ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    in_valid <= 1'b0;
                end else if (pending_frames.size() > 0) begin
                    if (idle_enabled && $urandom_range(99) < 25) begin
                        send_gap = pick_gap() - 1;
                        in_valid <= 1'b0;
                    end else begin
                        cur_frame    = pending_frames.pop_front();
                        front_left  <= cur_frame.fl;
                        front_right <= cur_frame.fr;
                        rear_left   <= cur_frame.rl;
                        rear_right  <= cur_frame.rr;
                        block_end   <= cur_frame.block_end;
                        in_valid    <= 1'b1;
                    end
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Output monitor. Each word taken is compared field by field with the
    // oldest owed word. Ready is lowered for random stretches, and for one
    // long stretch on request so the pipeline backs up into the input side.
    always @(posedge clk) begin
        mix_result_t want, got;
        if (rst_n) begin
            if (out_valid && out_ready) begin
                got.slots[0]  = slot_0;
                got.slots[1]  = slot_1;
                got.slots[2]  = slot_2;
                got.slots[3]  = slot_3;
                got.count     = slot_count;
                got.block_end = block_end_out;
                if (owed_mixes.size() == 0) begin
                    $error("output word with nothing owed: slot_0 %0d, slot_count %0d",
                           slot_0, slot_count);
                    err_count++;
                end else begin
                    want = owed_mixes.pop_front();
                    for (int i = 0; i < SLOTS; i++) begin
                        if (got.slots[i] !== want.slots[i]) begin
                            $error("slot_%0d: expected %0d, got %0d", i,
                                   $signed(want.slots[i]), $signed(got.slots[i]));
                            err_count++;
                        end
                    end
                    if (got.count !== want.count) begin
                        $error("slot_count: expected %0d, got %0d", want.count, got.count);
                        err_count++;
                    end
                    if (got.block_end !== want.block_end) begin
                        $error("block_end_out: expected %0d, got %0d",
                               want.block_end, got.block_end);
                        err_count++;
                    end
                    checked_total++;
                end
            end

            if (hold_cnt > 0) begin
                hold_cnt--;
                out_ready <= 1'b0;
            end else if (hold_request) begin
                hold_request = 1'b0;
                hold_cnt = LONG_HOLD - 1;
                out_ready <= 1'b0;
            end else if (idle_enabled && $urandom_range(99) < 20) begin
                hold_cnt = pick_gap() - 1;
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    // Watchdog: far beyond the slowest legal run, including the long hold.
    initial begin
        #2000000;
        $display("TB_ERROR");
        $finish;
    end

    // Stimulus: a short directed pass, then randomized phases that walk every
    // host code against every layout with random gains and swap.
    initial begin
        int phase;
        int rand_sent;
        int n;
        host_t h;
        layout_t l;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Reset settings: unity gains, four slots, straight quad order.
        push_frame(SAMPLE_MAX, SAMPLE_MIN, '0, SAMPLE_NEG1, 1'b0);
        push_frame(SAMPLE_MIN, SAMPLE_MAX, SAMPLE_NEG1, '0, 1'b1);
        push_frame(SB'(1), SAMPLE_NEG1, SB'(32767), SB'(-32768), 1'b0);
        push_frame(SB'(32768), SB'(-32769), SB'(65535), SB'(-65536), 1'b1);
        wait_idle();

        // Gains above unity with full-scale inputs: each split mix saturates or cancels.
        program_all('1, '1, '1, '1, HOST_FOUR, LAYOUT_SPLIT, 1'b1);
        push_frame(SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MIN, 1'b1);
        push_frame(SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MIN, 1'b0);
        wait_idle();

        // Zero gains silence everything.
        program_all('0, '0, '0, '0, HOST_FOUR, LAYOUT_STEREO_LR, 1'b0);
        push_frame(SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MIN, 1'b1);
        wait_idle();

        // One slot: mono mix, including a sum that truncates toward zero.
        program_all(GAIN_RESET, GAIN_RESET, GAIN_RESET, GAIN_RESET,
                    HOST_ONE, LAYOUT_QUAD_FRL, 1'b1);
        push_frame(SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, 1'b0);
        push_frame(SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MIN, 1'b1);
        push_frame(SB'(3), SAMPLE_NEG1, SAMPLE_NEG1, SB'(-2), 1'b0);
        wait_idle();

        // Two slots on a reversed layout: the swap is toggled.
        program_all(GAIN_RESET, GAIN_W'(16384), GAIN_W'(8192), GAIN_W'(1),
                    HOST_TWO, LAYOUT_STEREO_RL, 1'b0);
        push_frame(SB'(100), SB'(-100), SB'(7), SB'(-9), 1'b1);
        push_frame(SAMPLE_MAX, '0, SAMPLE_MIN, '0, 1'b0);
        wait_idle();

        // The unused host code behaves as four slots; mono goes to all four.
        program_all(GAIN_RESET, GAIN_RESET, GAIN_RESET, GAIN_RESET,
                    HOST_UNUSED, LAYOUT_MONO, 1'b0);
        push_frame(SB'(1), SB'(2), SB'(3), SB'(-7), 1'b0);
        wait_idle();

        // A write to the reserved index must not disturb any setting.
        write_reg(CFG_RESERVED, CFG_DATA_W'($urandom()));
        program_all(GAIN_RESET, GAIN_RESET, GAIN_RESET, GAIN_RESET,
                    HOST_FOUR, LAYOUT_QUAD_RRL, 1'b1);
        push_frame(SB'(1), SB'(2), SB'(3), SB'(4), 1'b1);
        wait_idle();

        // Random phases. Host and layout step through all 32 pairs in turn.
        phase = 0;
        rand_sent = 0;
        while (rand_sent < RAND_WORDS) begin
            h = host_t'(phase % 4);
            l = layout_t'((phase / 4) % 8);
            program_all(rand_gain(), rand_gain(), rand_gain(), rand_gain(),
                        h, l, 1'($urandom_range(1)));
            if ($urandom_range(7) == 0)
                write_reg(CFG_RESERVED, CFG_DATA_W'($urandom()));

            if (phase == 6) begin
                // Back-pressure phase: the sender streams with no gaps while
                // the receiver refuses words for a long stretch.
                idle_enabled = 1'b0;
                hold_request = 1'b1;
                n = 40;
            end else begin
                idle_enabled = ($urandom_range(3) != 0);
                n = $urandom_range(20, 36);
            end

            for (int i = 0; i < n; i++)
                push_frame(rand_sample(), rand_sample(), rand_sample(), rand_sample(),
                           ($urandom_range(7) == 0));
            rand_sent += n;
            wait_idle();
            phase++;
        end

        repeat (10) @(posedge clk);
        if (err_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

>>> sim.f
hw/rtl/qadr_pkg.sv
hw/rtl/qadr_gain_lane.sv
hw/rtl/qadr_mix_router.sv
hw/rtl/quad_audio_downmix_router_unit.sv
bench/tb_quad_audio_downmix_router_unit.sv
